// ----- design/tpm_pkg.sv -----
package tpm_pkg;

    // Default number of angle iterations in each angle unit.
    localparam int TPM_ANGLE_STEPS = 24;

    // Fixed pipeline section lengths.
    localparam int DIV_STEPS  = 48;
    localparam int CUBE_STEPS = 16;
    localparam int NORM_STEPS = 6;
    localparam int SQS_STEPS  = 5;
    localparam int ROOT_STEPS = 32;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_SIZE_X   = 3'd3,
        CFG_SIZE_Y   = 3'd4,
        CFG_SIZE_Z   = 3'd5,
        CFG_MODE     = 3'd6,
        CFG_AXIS     = 3'd7
    } t_cfg_idx;

    // Projection modes.
    localparam logic [2:0] MODE_PLANAR = 3'd1;
    localparam logic [2:0] MODE_CYL    = 3'd2;
    localparam logic [2:0] MODE_SPH    = 3'd3;
    localparam logic [2:0] MODE_CUBIC  = 3'd4;

    // Projection axis codes.
    localparam logic [2:0] AXIS_X = 3'b001;
    localparam logic [2:0] AXIS_Y = 3'b010;
    localparam logic [2:0] AXIS_Z = 3'b100;

    // Result status codes.
    localparam logic [1:0] ST_MAPPED   = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;

    localparam logic signed [33:0] HALF_TURN = 34'sh080000000;

    // One item as it travels down the pipeline.
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][47:0]      dq;
        logic [2:0][30:0]      rem;
        logic [1:0]            status;
        logic signed [48:0]    ca;
        logic signed [48:0]    cb;
        logic signed [48:0]    cc;
        logic [2:0][47:0]      sm;
        logic [1:0]            cneg;
        logic [47:0]           cd;
        logic [1:0][49:0]      crem;
        logic [1:0][15:0]      cq;
        logic signed [53:0]    cx;
        logic signed [53:0]    cy;
        logic [50:0]           cm;
        logic signed [33:0]    acc;
        logic signed [33:0]    acc1;
        logic                  czero;
        logic [62:0]           sq;
        logic [61:0]           pb;
        logic [62:0]           root;
    } t_item;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] atan_turn(input int i);
        case (i)
            0:  return 30'd536870912;
            1:  return 30'd316933406;
            2:  return 30'd167458907;
            3:  return 30'd85004756;
            4:  return 30'd42667331;
            5:  return 30'd21354465;
            6:  return 30'd10679838;
            7:  return 30'd5340245;
            8:  return 30'd2670163;
            9:  return 30'd1335087;
            10: return 30'd667544;
            11: return 30'd333772;
            12: return 30'd166886;
            13: return 30'd83443;
            14: return 30'd41722;
            15: return 30'd20861;
            16: return 30'd10430;
            17: return 30'd5215;
            18: return 30'd2608;
            19: return 30'd1304;
            20: return 30'd652;
            21: return 30'd326;
            22: return 30'd163;
            23: return 30'd81;
            24: return 30'd41;
            25: return 30'd20;
            26: return 30'd10;
            27: return 30'd5;
            28: return 30'd3;
            29: return 30'd1;
            30: return 30'd1;
            default: return 30'd0;
        endcase
    endfunction

    // One restoring division step on all three axes.
    function automatic t_item div_step(input t_item p, input logic [2:0][30:0] dv);
        t_item n;
        logic [31:0] t;
        n = p;
        for (int j = 0; j < 3; j++) begin
            t = {p.rem[j], p.dq[j][47]};
            if (t >= {1'b0, dv[j]}) begin
                n.rem[j] = 31'(t - {1'b0, dv[j]});
                n.dq[j]  = {p.dq[j][46:0], 1'b1};
            end else begin
                n.rem[j] = t[30:0];
                n.dq[j]  = {p.dq[j][46:0], 1'b0};
            end
        end
        return n;
    endfunction

    // Status, axis roles and the cubic face selection.
    function automatic t_item sel_step(input t_item p, input logic [2:0] mode,
                                       input logic [2:0] axis);
        t_item n;
        logic [2:0][47:0] m;
        logic signed [2:0][48:0] s;
        n = p;
        for (int j = 0; j < 3; j++) begin
            m[j] = p.dq[j];
            s[j] = p.neg[j] ? -$signed({1'b0, p.dq[j]}) : $signed({1'b0, p.dq[j]});
        end
        // Dominant component; x wins ties, then y.
        if (m[0] >= m[1] && m[0] >= m[2]) begin
            n.cd      = m[0];
            n.crem[0] = {2'b00, m[1]};
            n.crem[1] = {2'b00, m[2]};
            n.cneg    = {p.neg[2] ^ p.neg[0], p.neg[1] ^ p.neg[0]};
        end else if (m[1] >= m[2]) begin
            n.cd      = m[1];
            n.crem[0] = {2'b00, m[0]};
            n.crem[1] = {2'b00, m[2]};
            n.cneg    = {p.neg[2] ^ p.neg[1], p.neg[0] ^ p.neg[1]};
        end else begin
            n.cd      = m[2];
            n.crem[0] = {2'b00, m[0]};
            n.crem[1] = {2'b00, m[1]};
            n.cneg    = {p.neg[1] ^ p.neg[2], p.neg[0] ^ p.neg[2]};
        end
        n.cq = '0;
        if (mode == MODE_CUBIC) begin
            n.status = (n.cd == '0) ? ST_DIVZERO : ST_MAPPED;
        end else if ((mode == MODE_PLANAR || mode == MODE_CYL || mode == MODE_SPH) &&
                     (axis == AXIS_X || axis == AXIS_Y || axis == AXIS_Z)) begin
            n.status = ST_MAPPED;
        end else begin
            n.status = ST_UNMAPPED;
        end
        case (axis)
            AXIS_X: begin
                n.ca = s[1]; n.cb = s[2]; n.cc = s[0];
                n.sm[0] = m[1]; n.sm[1] = m[2]; n.sm[2] = m[0];
            end
            AXIS_Z: begin
                n.ca = s[0]; n.cb = s[2]; n.cc = s[1];
                n.sm[0] = m[0]; n.sm[1] = m[2]; n.sm[2] = m[1];
            end
            default: begin
                n.ca = s[0]; n.cb = s[1]; n.cc = s[2];
                n.sm[0] = m[0]; n.sm[1] = m[1]; n.sm[2] = m[2];
            end
        endcase
        return n;
    endfunction

    // One quotient bit of n * 2^15 / d for both cubic coordinates.
    function automatic t_item cube_step(input t_item p);
        t_item n;
        logic [49:0] t;
        logic b;
        n = p;
        for (int j = 0; j < 2; j++) begin
            if (p.crem[j] >= {2'b00, p.cd}) begin
                t = p.crem[j] - {2'b00, p.cd};
                b = 1'b1;
            end else begin
                t = p.crem[j];
                b = 1'b0;
            end
            n.crem[j] = {t[48:0], 1'b0};
            n.cq[j]   = {p.cq[j][14:0], b};
        end
        return n;
    endfunction

    // Angle unit entry: origin flag and the half-turn pre-rotation.
    function automatic t_item cordic_prep(input t_item p, input logic signed [53:0] y,
                                          input logic signed [53:0] x);
        t_item n;
        logic signed [53:0] xx;
        logic signed [53:0] yy;
        logic signed [53:0] ay;
        n = p;
        n.czero = (x == '0) && (y == '0);
        if (x < 0) begin
            n.acc = (y >= 0) ? HALF_TURN : -HALF_TURN;
            xx = -x;
            yy = -y;
        end else begin
            n.acc = '0;
            xx = x;
            yy = y;
        end
        ay   = (yy < 0) ? -yy : yy;
        n.cx = xx;
        n.cy = yy;
        n.cm = 51'(xx | ay);
        return n;
    endfunction

    // One binary step of the left normalization.
    function automatic t_item norm_step(input t_item p, input int amt);
        t_item n;
        n = p;
        if ((p.cm >> (51 - amt)) == '0) begin
            n.cx = p.cx <<< amt;
            n.cy = p.cy <<< amt;
            n.cm = p.cm << amt;
        end
        return n;
    endfunction

    // One vectoring rotation; the angle of the origin stays at zero.
    function automatic t_item iter_step(input t_item p, input int i);
        t_item n;
        logic signed [53:0] dx;
        logic signed [53:0] dy;
        logic signed [33:0] da;
        n  = p;
        dx = p.cy >>> i;
        dy = p.cx >>> i;
        if (p.czero) begin
            da = '0;
        end else begin
            da = $signed({4'b0000, atan_turn(i)});
        end
        if (!p.cy[53]) begin
            n.cx  = p.cx + dx;
            n.cy  = p.cy - dy;
            n.acc = p.acc + da;
        end else begin
            n.cx  = p.cx - dx;
            n.cy  = p.cy + dy;
            n.acc = p.acc - da;
        end
        return n;
    endfunction

    // One binary step of the common right shift that brings all below 2^31.
    function automatic t_item sqs_step(input t_item p, input int amt);
        t_item n;
        logic [47:0] m;
        n = p;
        m = p.sm[0] | p.sm[1] | p.sm[2];
        if ((m >> (30 + amt)) != '0) begin
            for (int j = 0; j < 3; j++) begin
                n.sm[j] = p.sm[j] >> amt;
            end
        end
        return n;
    endfunction

    // Squares of the two radius components.
    function automatic t_item mul_step(input t_item p);
        t_item n;
        logic [61:0] pa;
        logic [61:0] pb;
        n    = p;
        pa   = p.sm[0][30:0] * p.sm[0][30:0];
        pb   = p.sm[1][30:0] * p.sm[1][30:0];
        n.sq = {1'b0, pa};
        n.pb = pb;
        return n;
    endfunction

    function automatic t_item add_step(input t_item p);
        t_item n;
        n      = p;
        n.sq   = p.sq + {1'b0, p.pb};
        n.root = '0;
        return n;
    endfunction

    // One digit of the integer square root.
    function automatic t_item root_step(input t_item p, input int k);
        t_item n;
        logic [62:0] b;
        logic [63:0] t;
        n = p;
        b = 63'(1) << (62 - 2 * k);
        t = {1'b0, p.root} + {1'b0, b};
        if ({1'b0, p.sq} >= t) begin
            n.sq   = p.sq - t[62:0];
            n.root = (p.root >> 1) + b;
        end else begin
            n.root = p.root >> 1;
        end
        return n;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            return 32'h7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- design/tpm_in_if.sv -----
interface tpm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

// ----- design/tpm_out_if.sv -----
interface tpm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [1:0]         map_status;

    modport source (output valid, output tex_u, output tex_v, output map_status,
                    input ready);
    modport sink (input valid, input tex_u, input tex_v, input map_status,
                  output ready);
endinterface

// ----- design/texture_projection_mapper_core.sv -----
// Texture projection mapper: maps each vertex position (signed Q16.16) to a texture
// coordinate pair with a planar, cylindrical, spherical or cubic projection. The block
// takes one vertex per cycle unless the result side stalls. Its pipeline is made of the
// entry register, a 48-step bit-serial divider, the axis selection stage, a 16-step cubic
// divider, two angle units of ANGLE_STEPS rotations plus seven setup stages each, a
// 39-stage square root path and the output register, all one step per stage. When the
// result side stalls, the whole pipeline holds. The user must write the configuration
// registers only while no vertex is in flight; the block itself does not enforce this.
module texture_projection_mapper_core #(
    parameter int ANGLE_STEPS = tpm_pkg::TPM_ANGLE_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    tpm_in_if.sink      i_pnt,
    tpm_out_if.source   o_tex
);
    import tpm_pkg::*;

    // Stage positions along the pipeline.
    localparam int S_DIV0 = 1;
    localparam int S_SEL  = S_DIV0 + DIV_STEPS;
    localparam int S_CUB0 = S_SEL + 1;
    localparam int S_C1P  = S_CUB0 + CUBE_STEPS;
    localparam int S_C1N  = S_C1P + 1;
    localparam int S_C1I  = S_C1N + NORM_STEPS;
    localparam int S_SQS  = S_C1I + ANGLE_STEPS;
    localparam int S_MUL  = S_SQS + SQS_STEPS;
    localparam int S_ADD  = S_MUL + 1;
    localparam int S_RT0  = S_ADD + 1;
    localparam int S_C2P  = S_RT0 + ROOT_STEPS;
    localparam int S_C2N  = S_C2P + 1;
    localparam int S_C2I  = S_C2N + NORM_STEPS;
    localparam int DEPTH  = S_C2I + ANGLE_STEPS;

    logic signed [31:0] r_center [3];
    logic [30:0]        r_size [3];
    logic [2:0]         r_mode;
    logic [2:0]         r_axis;
    logic [2:0][30:0]   w_div;

    t_item              r_pipe [DEPTH];
    t_item              n_pipe [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic               w_en;

    logic               r_out_vld;
    logic [31:0]        r_tex_u;
    logic [31:0]        r_tex_v;
    logic [1:0]         r_status;
    logic [31:0]        n_tex_u;
    logic [31:0]        n_tex_v;
    logic [1:0]         n_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_center[j] <= '0;
                r_size[j]   <= 31'd65536;
            end
            r_mode <= '0;
            r_axis <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                CFG_SIZE_X:   r_size[0]   <= i_cfg_data[30:0];
                CFG_SIZE_Y:   r_size[1]   <= i_cfg_data[30:0];
                CFG_SIZE_Z:   r_size[2]   <= i_cfg_data[30:0];
                CFG_MODE:     r_mode      <= i_cfg_data[2:0];
                CFG_AXIS:     r_axis      <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // A zero size divides as one.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_div[j] = (r_size[j] == '0) ? 31'd1 : r_size[j];
        end
    end

    // The pipeline advances unless a finished result is waiting.
    assign w_en        = !r_out_vld || o_tex.ready;
    assign i_pnt.ready = w_en;

    // Entry stage: offset from the center, split into sign and scaled magnitude.
    always_comb begin
        logic signed [2:0][31:0] pt;
        logic signed [32:0] df;
        logic [32:0] mg;
        pt[0] = i_pnt.point_x;
        pt[1] = i_pnt.point_y;
        pt[2] = i_pnt.point_z;
        n_pipe[0] = '0;
        for (int j = 0; j < 3; j++) begin
            df = 33'($signed(pt[j])) - 33'(r_center[j]);
            mg = df[32] ? 33'(-df) : 33'(df);
            n_pipe[0].neg[j] = df[32];
            n_pipe[0].dq[j]  = {mg[31:0], 16'h0000};
        end
    end

    // Stage logic, one step of work per register stage.
    for (genvar k = 1; k < DEPTH; k++) begin : g_stage
        if (k < S_SEL) begin : g_div
            always_comb n_pipe[k] = div_step(r_pipe[k-1], w_div);
        end else if (k == S_SEL) begin : g_sel
            always_comb n_pipe[k] = sel_step(r_pipe[k-1], r_mode, r_axis);
        end else if (k < S_C1P) begin : g_cube
            always_comb n_pipe[k] = cube_step(r_pipe[k-1]);
        end else if (k == S_C1P) begin : g_c1p
            always_comb n_pipe[k] = cordic_prep(r_pipe[k-1], 54'(r_pipe[k-1].ca),
                                                54'(r_pipe[k-1].cb));
        end else if (k < S_C1I) begin : g_c1n
            always_comb n_pipe[k] = norm_step(r_pipe[k-1], 32 >> (k - S_C1N));
        end else if (k < S_SQS) begin : g_c1i
            always_comb n_pipe[k] = iter_step(r_pipe[k-1], k - S_C1I);
        end else if (k < S_MUL) begin : g_sqs
            // The first shift stage also keeps the first angle.
            always_comb begin
                n_pipe[k] = sqs_step(r_pipe[k-1], 16 >> (k - S_SQS));
                if (k == S_SQS) begin
                    n_pipe[k].acc1 = r_pipe[k-1].acc;
                end
            end
        end else if (k == S_MUL) begin : g_mul
            always_comb n_pipe[k] = mul_step(r_pipe[k-1]);
        end else if (k == S_ADD) begin : g_add
            always_comb n_pipe[k] = add_step(r_pipe[k-1]);
        end else if (k < S_C2P) begin : g_root
            always_comb n_pipe[k] = root_step(r_pipe[k-1], k - S_RT0);
        end else if (k == S_C2P) begin : g_c2p
            // Elevation takes the shifted height with the sign of c.
            always_comb begin
                logic signed [53:0] cs;
                cs = r_pipe[k-1].cc[48] ? -$signed({23'b0, r_pipe[k-1].sm[2][30:0]})
                                        : $signed({23'b0, r_pipe[k-1].sm[2][30:0]});
                n_pipe[k] = cordic_prep(r_pipe[k-1], cs,
                                        $signed({1'b0, r_pipe[k-1].root[52:0]}));
            end
        end else if (k < S_C2I) begin : g_c2n
            always_comb n_pipe[k] = norm_step(r_pipe[k-1], 32 >> (k - S_C2N));
        end else begin : g_c2i
            always_comb n_pipe[k] = iter_step(r_pipe[k-1], k - S_C2I);
        end
    end

    // Pipeline registers; valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_pnt.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    // Final mapping and saturation.
    always_comb begin
        t_item p;
        logic signed [50:0] ang_u;
        logic signed [50:0] ang_v;
        logic signed [50:0] cu;
        logic signed [50:0] cv;
        p     = r_pipe[DEPTH-1];
        ang_u = ((51'(p.acc1) + 51'sd32768) >>> 16) + 51'sd32768;
        ang_v = ((51'(p.acc) + 51'sd16384) >>> 15) + 51'sd32768;
        cu    = (p.cneg[0] ? -$signed({35'b0, p.cq[0]}) : $signed({35'b0, p.cq[0]}))
                + 51'sd32768;
        cv    = (p.cneg[1] ? -$signed({35'b0, p.cq[1]}) : $signed({35'b0, p.cq[1]}))
                + 51'sd32768;
        if (p.czero) begin
            ang_v = 51'sd32768;
        end
        n_tex_u  = '0;
        n_tex_v  = '0;
        n_status = p.status;
        if (p.status == ST_MAPPED) begin
            case (r_mode)
                MODE_CUBIC: begin
                    n_tex_u = sat32(cu);
                    n_tex_v = sat32(cv);
                end
                MODE_PLANAR: begin
                    n_tex_u = sat32(51'(p.ca) + 51'sd32768);
                    n_tex_v = sat32(51'(p.cb) + 51'sd32768);
                end
                MODE_CYL: begin
                    n_tex_u = sat32(ang_u);
                    n_tex_v = sat32(51'(p.cc) + 51'sd32768);
                end
                MODE_SPH: begin
                    n_tex_u = sat32(ang_u);
                    n_tex_v = sat32(ang_v);
                end
                default: begin
                    n_tex_u = '0;
                    n_tex_v = '0;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tex_u  <= n_tex_u;
            r_tex_v  <= n_tex_v;
            r_status <= n_status;
        end
    end

    assign o_tex.valid      = r_out_vld;
    assign o_tex.tex_u      = r_tex_u;
    assign o_tex.tex_v      = r_tex_v;
    assign o_tex.map_status = r_status;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns/1ps
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tpm_pkg::*;

    localparam int  STEPS      = TPM_ANGLE_STEPS;
    localparam int  LATENCY    = 120 + 2 * STEPS;
    localparam int  IDLE_LIMIT = 4000;
    localparam longint HALF_Q  = 32768;
    localparam longint HALF_T  = 64'sd2147483648;
    localparam longint NORM_LO = 64'sd1125899906842624;
    localparam longint SQ_LIM  = 64'sd2147483648;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vertex_t;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic [1:0]  st;
    } texel_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    tpm_in_if  pnt ();
    tpm_out_if tex ();

    texture_projection_mapper_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pnt      (pnt.sink),
        .o_tex      (tex.source)
    );

    // Arctangent of 2^-i in units of 2^-32 turn.
    longint atan_lut [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    // Shadow copy of the configuration registers.
    longint      cen [3];
    logic [30:0] ext [3];
    logic [2:0]  proj_mode;
    logic [2:0]  proj_axis;

    vertex_t pending_vertices [$];
    texel_t  expected_texels [$];
    int      errors;
    bit      calm;
    bit      in_fire;
    int      gap_left;
    int      stall_left;
    int      idle_cycles;

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Vectoring CORDIC: atan2(y, x) in 2^-32 turn units.
    function automatic longint turn_angle(longint y, longint x);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            acc = (y >= 0) ? HALF_T : -HALF_T;
            x = -x;
            y = -y;
        end
        while (absval(x) < NORM_LO && absval(y) < NORM_LO) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                acc += atan_lut[i];
            end else begin
                x -= dx;
                y += dy;
                acc -= atan_lut[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // n / (2d) in Q16.16, truncated toward zero.
    function automatic longint face_ratio(longint n, longint d);
        logic [63:0] un;
        logic [63:0] ud;
        longint q;
        un = absval(n);
        ud = absval(d);
        q = longint'((un << 15) / ud);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Expected texture coordinate for one vertex under the current settings.
    function automatic texel_t project_vertex(vertex_t p);
        longint sp [3];
        longint pv [3];
        longint u, v, a, b, c, d, n1, n2, ma, mb, mc, r, cs, dv;
        logic [63:0] sum;
        int s;
        logic [1:0] st;
        texel_t res;
        pv[0] = longint'($signed(p.x));
        pv[1] = longint'($signed(p.y));
        pv[2] = longint'($signed(p.z));
        u = 0;
        v = 0;
        st = ST_MAPPED;
        for (int i = 0; i < 3; i++) begin
            dv = (ext[i] == 0) ? 1 : longint'(ext[i]);
            sp[i] = ((pv[i] - cen[i]) * 65536) / dv;
        end
        if (proj_mode == MODE_CUBIC) begin
            if (absval(sp[0]) >= absval(sp[1]) && absval(sp[0]) >= absval(sp[2])) begin
                d = sp[0]; n1 = sp[1]; n2 = sp[2];
            end else if (absval(sp[1]) >= absval(sp[2])) begin
                d = sp[1]; n1 = sp[0]; n2 = sp[2];
            end else begin
                d = sp[2]; n1 = sp[0]; n2 = sp[1];
            end
            if (d == 0) begin
                st = ST_DIVZERO;
            end else begin
                u = face_ratio(n1, d) + HALF_Q;
                v = face_ratio(n2, d) + HALF_Q;
            end
        end else if ((proj_mode == MODE_PLANAR || proj_mode == MODE_CYL ||
                      proj_mode == MODE_SPH) &&
                     (proj_axis == AXIS_X || proj_axis == AXIS_Y || proj_axis == AXIS_Z)) begin
            if (proj_axis == AXIS_X) begin
                a = sp[1]; b = sp[2]; c = sp[0];
            end else if (proj_axis == AXIS_Y) begin
                a = sp[0]; b = sp[1]; c = sp[2];
            end else begin
                a = sp[0]; b = sp[2]; c = sp[1];
            end
            if (proj_mode == MODE_PLANAR) begin
                u = a + HALF_Q;
                v = b + HALF_Q;
            end else begin
                u = ((turn_angle(a, b) + 32768) >>> 16) + HALF_Q;
                if (proj_mode == MODE_CYL) begin
                    v = c + HALF_Q;
                end else begin
                    ma = absval(a);
                    mb = absval(b);
                    mc = absval(c);
                    s = 0;
                    while ((ma >> s) >= SQ_LIM || (mb >> s) >= SQ_LIM || (mc >> s) >= SQ_LIM)
                        s++;
                    ma = ma >> s;
                    mb = mb >> s;
                    mc = mc >> s;
                    sum = ma * ma + mb * mb;
                    r = longint'(int_sqrt(sum));
                    cs = c < 0 ? -mc : mc;
                    v = ((turn_angle(cs, r) + 16384) >>> 15) + HALF_Q;
                end
            end
        end else begin
            st = ST_UNMAPPED;
        end
        res.u = 32'(clamp32(u));
        res.v = 32'(clamp32(v));
        res.st = st;
        return res;
    endfunction

    // Random coordinate: full range, near zero, extremes or a value from -1 to 2.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2, 3:    return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
            4:       return ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($urandom_range(0, 3)) - 32'd1;
        endcase
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 4))
            0:       return 32'($urandom_range(1, 1 << 17));
            1:       return $urandom & 32'h7FFFFFFF;
            2:       return 32'($urandom_range(0, 3));
            3:       return 32'h7FFFFFFF;
            default: return 32'd65536;
        endcase
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CENTER_X: cen[0] = longint'($signed(data));
            CFG_CENTER_Y: cen[1] = longint'($signed(data));
            CFG_CENTER_Z: cen[2] = longint'($signed(data));
            CFG_SIZE_X:   ext[0] = data[30:0];
            CFG_SIZE_Y:   ext[1] = data[30:0];
            CFG_SIZE_Z:   ext[2] = data[30:0];
            CFG_MODE:     proj_mode = data[2:0];
            default:      proj_axis = data[2:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every vertex has been sent and every result has come back.
    task automatic drain();
        wait (pending_vertices.size() == 0 && expected_texels.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vertex_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_vertices.insert(pending_vertices.size(), p);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Input side: detect the transfer and predict its result.
    always @(posedge i_clk) begin
        in_fire = pnt.valid && pnt.ready;
        if (in_fire) begin
            expected_texels.insert(expected_texels.size(),
                                   project_vertex(pending_vertices.pop_front()));
        end
    end

    // Output side: compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        texel_t got;
        texel_t want;
        if (tex.valid && tex.ready) begin
            got.u = tex.tex_u;
            got.v = tex.tex_v;
            got.st = tex.map_status;
            if (expected_texels.size() == 0) begin
                $display("%0t: unexpected result u=%h v=%h st=%0d",
                         $time, got.u, got.v, got.st);
                errors++;
            end else begin
                want = expected_texels.pop_front();
                if (got.u !== want.u) begin
                    $display("%0t: tex_u expected %h actual %h", $time, want.u, got.u);
                    errors++;
                end
                if (got.v !== want.v) begin
                    $display("%0t: tex_v expected %h actual %h", $time, want.v, got.v);
                    errors++;
                end
                if (got.st !== want.st) begin
                    $display("%0t: map_status expected %0d actual %0d",
                             $time, want.st, got.st);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer while work is outstanding.
    always @(posedge i_clk) begin
        if ((pnt.valid && pnt.ready) || (tex.valid && tex.ready) ||
            (pending_vertices.size() == 0 && expected_texels.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Vertex driver with random gaps; a presented vertex holds until its transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pnt.valid <= 1'b0;
        end else if (pnt.valid && !in_fire) begin
        end else if (gap_left > 0) begin
            gap_left--;
            pnt.valid <= 1'b0;
        end else if (!calm && pending_vertices.size() > 0 && $urandom_range(0, 15) == 0) begin
            gap_left = $urandom_range(0, 14);
            pnt.valid <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
            pnt.valid   <= 1'b1;
            pnt.point_x <= pending_vertices[0].x;
            pnt.point_y <= pending_vertices[0].y;
            pnt.point_z <= pending_vertices[0].z;
        end else begin
            pnt.valid <= 1'b0;
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            tex.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 14);
            tex.ready <= 1'b0;
        end else begin
            tex.ready <= 1'b1;
        end
    end

    // Stimulus: directed vertices, then randomized phases of settings.
    initial begin
        pnt.valid   = 1'b0;
        pnt.point_x = '0;
        pnt.point_y = '0;
        pnt.point_z = '0;
        tex.ready   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_CENTER_X;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        errors      = 0;
        calm        = 1'b0;
        gap_left    = 0;
        stall_left  = 0;
        idle_cycles = 0;
        in_fire     = 1'b0;
        for (int i = 0; i < 3; i++) begin
            cen[i] = 0;
            ext[i] = 31'd65536;
        end
        proj_mode = '0;
        proj_axis = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: mode zero leaves every vertex unmapped.
        add_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0);
        drain();

        // Planar on y with extreme coordinates.
        cfg_write(CFG_MODE, 32'(MODE_PLANAR));
        cfg_write(CFG_AXIS, 32'(AXIS_Y));
        add_vertex(32'h7FFFFFFF, 32'h80000000, 32'h0);
        add_vertex(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        add_vertex(32'h0, 32'h0, 32'h0);
        drain();

        // Cylindrical on z: origin angle and a negative second operand.
        cfg_write(CFG_MODE, 32'(MODE_CYL));
        cfg_write(CFG_AXIS, 32'(AXIS_Z));
        add_vertex(32'h0, 32'h0, 32'h0);
        add_vertex(32'h0, 32'h5, 32'hFFFF0000);
        add_vertex(32'h0, 32'h5, 32'hFFFF0000);
        add_vertex(32'hFFFFFFFF, 32'h0, 32'h80000000);
        add_vertex(32'h0001_0000, 32'h0, 32'h0001_0000);
        drain();

        // Spherical on x with large magnitudes.
        cfg_write(CFG_MODE, 32'(MODE_SPH));
        cfg_write(CFG_AXIS, 32'(AXIS_X));
        add_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        add_vertex(32'h80000000, 32'h0, 32'h0);
        add_vertex(32'h0, 32'h0, 32'h0);
        add_vertex(32'h0003_0000, 32'hFFFC_0000, 32'h0001_0000);
        drain();

        // Spherical with an axis that is not one-hot.
        cfg_write(CFG_AXIS, 32'd3);
        add_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        drain();

        // Cubic: center point, ties and a zero size on x.
        cfg_write(CFG_MODE, 32'(MODE_CUBIC));
        add_vertex(32'h0, 32'h0, 32'h0);
        add_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        add_vertex(32'h0, 32'h0002_0000, 32'hFFFE_0000);
        add_vertex(32'h80000000, 32'h7FFFFFFF, 32'h1);
        drain();
        cfg_write(CFG_SIZE_X, 32'd0);
        add_vertex(32'h3, 32'h7FFFFFFF, 32'h0);
        drain();

        // Random phases; the last one runs with no gaps or stalls.
        for (int ph = 0; ph < 16; ph++) begin
            if (ph == 15) calm = 1'b1;
            cfg_write(CFG_MODE, (ph < 8) ? 32'(ph) :
                      (($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) :
                       32'($urandom_range(1, 4))));
            cfg_write(CFG_AXIS, (ph < 8) ? 32'((ph * 3) % 8) :
                      (($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) :
                       32'(1 << $urandom_range(0, 2))));
            if (ph == 2) begin
                cfg_write(CFG_CENTER_X, 32'h80000000);
                cfg_write(CFG_CENTER_Y, 32'h7FFFFFFF);
                cfg_write(CFG_CENTER_Z, 32'h80000000);
                cfg_write(CFG_SIZE_X, 32'h7FFFFFFF);
                cfg_write(CFG_SIZE_Y, 32'd1);
                cfg_write(CFG_SIZE_Z, 32'd0);
            end else if (ph % 3 == 0) begin
                cfg_write(CFG_CENTER_X, 32'h0);
                cfg_write(CFG_CENTER_Y, 32'h0);
                cfg_write(CFG_CENTER_Z, 32'h0);
                cfg_write(CFG_SIZE_X, 32'd65536);
                cfg_write(CFG_SIZE_Y, 32'd65536);
                cfg_write(CFG_SIZE_Z, 32'd65536);
            end else begin
                cfg_write(CFG_CENTER_X, rand_coord());
                cfg_write(CFG_CENTER_Y, rand_coord());
                cfg_write(CFG_CENTER_Z, rand_coord());
                cfg_write(CFG_SIZE_X, rand_size());
                cfg_write(CFG_SIZE_Y, rand_size());
                cfg_write(CFG_SIZE_Z, rand_size());
            end
            for (int k = 0; k < 64; k++) begin
                add_vertex(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/tpm_pkg.sv
design/tpm_in_if.sv
design/tpm_out_if.sv
design/texture_projection_mapper_core.sv
tb/sv/testbench.sv
